// ----- rtl/oas_pkg.sv -----
// Shared types and constants for the obstacle avoidance steering block.
`default_nettype none
package oas_pkg;

    localparam int DIST_W  = 8;
    localparam int SPEED_W = 11;
    localparam int LIMIT_W = 10;
    localparam int WHEEL_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT   = 2'd3;

    localparam logic [DIST_W-1:0]  RST_STOP_DISTANCE = 8'd50;
    localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED  = 11'd1200;
    localparam logic [SPEED_W-1:0] RST_TURN_SPEED    = 11'd900;
    localparam logic [LIMIT_W-1:0] RST_ERROR_LIMIT   = 10'd1000;

    // Division by 25 as multiply by ceil(2^17 / 25) and shift; exact for magnitudes
    // below 43690, and the steering sum never exceeds 17850.
    localparam logic [12:0] DIV25_MUL   = 13'd5243;
    localparam int          DIV25_SHIFT = 17;

    typedef struct packed {
        logic [DIST_W-1:0]  stop_distance;
        logic [SPEED_W-1:0] cruise_speed;
        logic [SPEED_W-1:0] turn_speed;
        logic [LIMIT_W-1:0] error_limit;
    } t_cfg;

    typedef struct packed {
        logic spin_parity;
        logic was_free_running;
    } t_steer_state;

endpackage
`default_nettype wire

// ----- rtl/oas_cfg_regs.sv -----
// Configuration register file for the steering block.
`default_nettype none
module oas_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic [oas_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [oas_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output oas_pkg::t_cfg                       o_cfg
);

    oas_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop_distance <= oas_pkg::RST_STOP_DISTANCE;
            r_cfg.cruise_speed  <= oas_pkg::RST_CRUISE_SPEED;
            r_cfg.turn_speed    <= oas_pkg::RST_TURN_SPEED;
            r_cfg.error_limit   <= oas_pkg::RST_ERROR_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                oas_pkg::REG_STOP_DISTANCE: begin
                    r_cfg.stop_distance <= i_cfg_data[oas_pkg::DIST_W-1:0];
                end
                oas_pkg::REG_CRUISE_SPEED: begin
                    r_cfg.cruise_speed <= i_cfg_data[oas_pkg::SPEED_W-1:0];
                end
                oas_pkg::REG_TURN_SPEED: begin
                    r_cfg.turn_speed <= i_cfg_data[oas_pkg::SPEED_W-1:0];
                end
                oas_pkg::REG_ERROR_LIMIT: begin
                    r_cfg.error_limit <= i_cfg_data[oas_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- rtl/oas_steer_calc.sv -----
// Combinational steering datapath: obstacle test, weighted error and wheel speeds.
`default_nettype none
module oas_steer_calc (
    input  wire logic [oas_pkg::DIST_W-1:0] i_d0,
    input  wire logic [oas_pkg::DIST_W-1:0] i_d1,
    input  wire logic [oas_pkg::DIST_W-1:0] i_d2,
    input  wire logic [oas_pkg::DIST_W-1:0] i_d3,
    input  wire oas_pkg::t_cfg              i_cfg,
    input  wire oas_pkg::t_steer_state      i_state,
    output oas_pkg::t_steer_state           o_state,
    output logic signed [oas_pkg::WHEEL_W-1:0] o_left,
    output logic signed [oas_pkg::WHEEL_W-1:0] o_right,
    output logic                            o_obstacle
);

    logic [3:0]  near;
    logic [7:0]  a0, a1, a2, a3;
    logic signed [15:0] sum;
    logic [14:0] mag;
    logic [27:0] prod;
    logic [9:0]  quot;
    logic [9:0]  clamped;
    logic signed [12:0] err;
    logic        parity;
    logic signed [12:0] turn;
    logic signed [12:0] cruise;

    // A missing reading counts as 255, so its distance deficit is zero.
    assign a0 = (i_d0 == 8'd0) ? 8'd0 : (8'd255 - i_d0);
    assign a1 = (i_d1 == 8'd0) ? 8'd0 : (8'd255 - i_d1);
    assign a2 = (i_d2 == 8'd0) ? 8'd0 : (8'd255 - i_d2);
    assign a3 = (i_d3 == 8'd0) ? 8'd0 : (8'd255 - i_d3);

    assign near[0] = (i_d0 != 8'd0) && (i_d0 < i_cfg.stop_distance);
    assign near[1] = (i_d1 != 8'd0) && (i_d1 < i_cfg.stop_distance);
    assign near[2] = (i_d2 != 8'd0) && (i_d2 < i_cfg.stop_distance);
    assign near[3] = (i_d3 != 8'd0) && (i_d3 < i_cfg.stop_distance);
    assign o_obstacle = |near;

    assign sum = 16'sd50 * ($signed({8'd0, a3}) - $signed({8'd0, a0}))
               + 16'sd10 * ($signed({8'd0, a1}) + $signed({8'd0, a2}));

    // Truncation toward zero: divide the magnitude, then restore the sign.
    assign mag  = sum[15] ? 15'(-sum) : sum[14:0];
    assign prod = {13'd0, mag} * {15'd0, oas_pkg::DIV25_MUL};
    assign quot = prod[oas_pkg::DIV25_SHIFT +: 10];
    assign clamped = (quot > i_cfg.error_limit) ? i_cfg.error_limit : quot;
    assign err = sum[15] ? -$signed({3'd0, clamped}) : $signed({3'd0, clamped});

    assign cruise = $signed({2'd0, i_cfg.cruise_speed});
    assign turn   = $signed({2'd0, i_cfg.turn_speed});

    // Each fresh obstacle after free running flips the spin direction.
    assign parity = i_state.spin_parity ^ i_state.was_free_running;

    always_comb begin
        if (o_obstacle) begin
            o_state.spin_parity      = parity;
            o_state.was_free_running = 1'b0;
            o_left  = parity ? turn : -turn;
            o_right = parity ? -turn : turn;
        end else begin
            o_state.spin_parity      = i_state.spin_parity;
            o_state.was_free_running = 1'b1;
            o_left  = cruise - err;
            o_right = cruise + err;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/obstacle_avoid_steering.sv -----
// Path: an accepted item goes to the input register, then to the result register, which can stall.
// Throughput: one item per cycle while the result is not stalled.
// The input side stalls only when both registers hold items and the result is stalled.
// Synchronous active-low reset empties both stages, clears the spin state and
// restores the configuration registers to their defaults.
`default_nettype none
module obstacle_avoid_steering (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [oas_pkg::DIST_W-1:0]     i_diag_left_distance,
    input  wire logic [oas_pkg::DIST_W-1:0]     i_left_distance,
    input  wire logic [oas_pkg::DIST_W-1:0]     i_right_distance,
    input  wire logic [oas_pkg::DIST_W-1:0]     i_diag_right_distance,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed [oas_pkg::WHEEL_W-1:0]  o_left_wheel_speed,
    output logic signed [oas_pkg::WHEEL_W-1:0]  o_right_wheel_speed,
    output logic                                o_obstacle_seen,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [oas_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [oas_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    oas_pkg::t_cfg         cfg;
    oas_pkg::t_steer_state r_state, n_state;

    logic r_s1_valid, n_s1_valid;
    logic [oas_pkg::DIST_W-1:0] r_d0, r_d1, r_d2, r_d3;
    logic r_out_valid, n_out_valid;
    logic signed [oas_pkg::WHEEL_W-1:0] r_left, r_right, n_left, n_right;
    logic r_obstacle, n_obstacle;

    logic out_free;
    logic s1_move;
    logic in_take;

    assign o_cfg_ready = 1'b1;

    oas_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    oas_steer_calc u_calc (
        .i_d0       (r_d0),
        .i_d1       (r_d1),
        .i_d2       (r_d2),
        .i_d3       (r_d3),
        .i_cfg      (cfg),
        .i_state    (r_state),
        .o_state    (n_state),
        .o_left     (n_left),
        .o_right    (n_right),
        .o_obstacle (n_obstacle)
    );

    // The result register can take a new item when empty or being emptied.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_take) begin
            n_s1_valid = 1'b1;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_move) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid              <= 1'b0;
            r_out_valid             <= 1'b0;
            r_state.spin_parity      <= 1'b0;
            r_state.was_free_running <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (s1_move) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_d0 <= i_diag_left_distance;
            r_d1 <= i_left_distance;
            r_d2 <= i_right_distance;
            r_d3 <= i_diag_right_distance;
        end
        if (s1_move) begin
            r_left     <= n_left;
            r_right    <= n_right;
            r_obstacle <= n_obstacle;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_left_wheel_speed  = r_left;
    assign o_right_wheel_speed = r_right;
    assign o_obstacle_seen     = r_obstacle;

endmodule
`default_nettype wire

// ----- tb/obstacle_avoid_steering_tb.sv -----
// Self-checking testbench for the obstacle avoidance steering block.
module obstacle_avoid_steering_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int SETTLE_CYCLES  = 6;

    typedef struct {
        logic signed [oas_pkg::WHEEL_W-1:0] left;
        logic signed [oas_pkg::WHEEL_W-1:0] right;
        logic                               seen;
    } t_wheel_cmd;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [oas_pkg::DIST_W-1:0] i_diag_left_distance = '0;
    logic [oas_pkg::DIST_W-1:0] i_left_distance = '0;
    logic [oas_pkg::DIST_W-1:0] i_right_distance = '0;
    logic [oas_pkg::DIST_W-1:0] i_diag_right_distance = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [oas_pkg::WHEEL_W-1:0] o_left_wheel_speed;
    logic signed [oas_pkg::WHEEL_W-1:0] o_right_wheel_speed;
    logic                    o_obstacle_seen;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [oas_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [oas_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    oas_pkg::t_cfg         steer_cfg;
    oas_pkg::t_steer_state steer_st;
    t_wheel_cmd            wheel_cmd_q[$];

    int  fail_count = 0;
    int  cycle_count = 0;
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    int  holdoff_left = 0;
    logic holdoff_req = 1'b0;

    obstacle_avoid_steering dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_diag_left_distance  (i_diag_left_distance),
        .i_left_distance       (i_left_distance),
        .i_right_distance      (i_right_distance),
        .i_diag_right_distance (i_diag_right_distance),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_left_wheel_speed    (o_left_wheel_speed),
        .o_right_wheel_speed   (o_right_wheel_speed),
        .o_obstacle_seen       (o_obstacle_seen),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Works out the wheel command for one set of readings and advances the spin state.
    function automatic t_wheel_cmd steer_predict(input logic [oas_pkg::DIST_W-1:0] dl, l, r, dr);
        logic [oas_pkg::DIST_W-1:0] d [4];
        int weight [4];
        int sum;
        int err;
        int lim;
        int reading;
        int turn;
        logic obstacle;
        t_wheel_cmd cmd;
        d = '{dl, l, r, dr};
        weight = '{-50, 10, 10, 50};
        obstacle = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (d[i] != '0 && d[i] < steer_cfg.stop_distance)
                obstacle = 1'b1;
        end
        if (obstacle) begin
            turn = int'(steer_cfg.turn_speed);
            // The spin direction only flips when an obstacle follows free steering.
            if (steer_st.was_free_running)
                steer_st.spin_parity = ~steer_st.spin_parity;
            cmd.left  = oas_pkg::WHEEL_W'(steer_st.spin_parity ? turn : -turn);
            cmd.right = oas_pkg::WHEEL_W'(steer_st.spin_parity ? -turn : turn);
            cmd.seen  = 1'b1;
            steer_st.was_free_running = 1'b0;
        end else begin
            sum = 0;
            for (int i = 0; i < 4; i++) begin
                reading = (d[i] == '0) ? 255 : int'(d[i]);
                sum += weight[i] * (255 - reading);
            end
            err = sum / 25;
            lim = int'(steer_cfg.error_limit);
            if (err > lim)
                err = lim;
            if (err < -lim)
                err = -lim;
            cmd.left  = oas_pkg::WHEEL_W'(int'(steer_cfg.cruise_speed) - err);
            cmd.right = oas_pkg::WHEEL_W'(int'(steer_cfg.cruise_speed) + err);
            cmd.seen  = 1'b0;
            steer_st.was_free_running = 1'b1;
        end
        return cmd;
    endfunction

    // Tracks configuration writes and accepted items at the same edges as the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            steer_cfg = '{oas_pkg::RST_STOP_DISTANCE, oas_pkg::RST_CRUISE_SPEED,
                          oas_pkg::RST_TURN_SPEED, oas_pkg::RST_ERROR_LIMIT};
            steer_st  = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    oas_pkg::REG_STOP_DISTANCE:
                        steer_cfg.stop_distance = i_cfg_data[oas_pkg::DIST_W-1:0];
                    oas_pkg::REG_CRUISE_SPEED:
                        steer_cfg.cruise_speed  = i_cfg_data[oas_pkg::SPEED_W-1:0];
                    oas_pkg::REG_TURN_SPEED:
                        steer_cfg.turn_speed    = i_cfg_data[oas_pkg::SPEED_W-1:0];
                    oas_pkg::REG_ERROR_LIMIT:
                        steer_cfg.error_limit   = i_cfg_data[oas_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall)
                wheel_cmd_q.push_back(steer_predict(i_diag_left_distance, i_left_distance,
                                                    i_right_distance, i_diag_right_distance));
        end
    end

    always @(posedge i_clk) begin
        t_wheel_cmd want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (wheel_cmd_q.size() == 0) begin
                $display("%0t: unexpected result: left %0d right %0d obstacle %0b", $time,
                         o_left_wheel_speed, o_right_wheel_speed, o_obstacle_seen);
                fail_count++;
            end else begin
                want = wheel_cmd_q.pop_front();
                if (o_left_wheel_speed !== want.left) begin
                    $display("%0t: left wheel speed expected %0d, got %0d", $time,
                             want.left, o_left_wheel_speed);
                    fail_count++;
                end
                if (o_right_wheel_speed !== want.right) begin
                    $display("%0t: right wheel speed expected %0d, got %0d", $time,
                             want.right, o_right_wheel_speed);
                    fail_count++;
                end
                if (o_obstacle_seen !== want.seen) begin
                    $display("%0t: obstacle flag expected %0b, got %0b", $time,
                             want.seen, o_obstacle_seen);
                    fail_count++;
                end
            end
        end
    end

    // Result side: random stalls, or a long hold-off on request.
    always @(negedge i_clk) begin
        if (holdoff_req) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_req = 1'b0;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("obstacle_avoid_steering_tb NOT OK");
            $finish;
        end
    end

    task automatic send_reading(input logic [oas_pkg::DIST_W-1:0] dl, l, r, dr);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid            <= 1'b1;
        i_diag_left_distance  <= dl;
        i_left_distance       <= l;
        i_right_distance      <= r;
        i_diag_right_distance <= dr;
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    task automatic write_reg(input logic [oas_pkg::CFG_IDX_W-1:0] index,
                             input logic [oas_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stops offering items and waits until every expected result has come out.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (wheel_cmd_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_random_config();
        logic [oas_pkg::DIST_W-1:0]  stop;
        logic [oas_pkg::SPEED_W-1:0] cruise;
        logic [oas_pkg::SPEED_W-1:0] turn;
        logic [oas_pkg::LIMIT_W-1:0] lim;
        case ($urandom_range(5))
            0:       stop = '0;
            1:       stop = '1;
            default: stop = oas_pkg::DIST_W'($urandom_range(20, 160));
        endcase
        case ($urandom_range(3))
            0:       cruise = '0;
            1:       cruise = '1;
            default: cruise = oas_pkg::SPEED_W'($urandom);
        endcase
        case ($urandom_range(3))
            0:       turn = '0;
            1:       turn = '1;
            default: turn = oas_pkg::SPEED_W'($urandom);
        endcase
        case ($urandom_range(4))
            0:       lim = '0;
            1:       lim = '1;
            2:       lim = oas_pkg::LIMIT_W'($urandom_range(1, 200));
            default: lim = oas_pkg::LIMIT_W'($urandom);
        endcase
        // Bits above a register's width are junk and must be dropped by the block.
        write_reg(oas_pkg::REG_STOP_DISTANCE, {3'($urandom_range(7)), stop});
        write_reg(oas_pkg::REG_CRUISE_SPEED, cruise);
        write_reg(oas_pkg::REG_TURN_SPEED, turn);
        write_reg(oas_pkg::REG_ERROR_LIMIT, {1'($urandom_range(1)), lim});
    endtask

    function automatic logic [oas_pkg::DIST_W-1:0] any_reading();
        int v;
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = 255;
            2, 3:    v = int'(steer_cfg.stop_distance) + int'($urandom_range(3)) - 2;
            default: v = int'($urandom_range(255));
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return oas_pkg::DIST_W'(v);
    endfunction

    // A reading that never counts as an obstacle under the current stop distance.
    function automatic logic [oas_pkg::DIST_W-1:0] clear_reading();
        if ($urandom_range(7) == 0)
            return '0;
        return oas_pkg::DIST_W'($urandom_range(255, int'(steer_cfg.stop_distance)));
    endfunction

    task automatic send_random_reading();
        // Mostly clear views, so that free steering and fresh obstacles alternate often.
        if ($urandom_range(9) < 6)
            send_reading(clear_reading(), clear_reading(), clear_reading(), clear_reading());
        else
            send_reading(any_reading(), any_reading(), any_reading(), any_reading());
    endtask

    task automatic test_reset_defaults();
        send_reading(8'd0, 8'd0, 8'd0, 8'd0);
        send_reading(8'd255, 8'd255, 8'd255, 8'd255);
        send_reading(8'd1, 8'd255, 8'd255, 8'd255);
        send_reading(8'd49, 8'd0, 8'd0, 8'd0);
        send_reading(8'd50, 8'd50, 8'd50, 8'd50);
        send_reading(8'd255, 8'd255, 8'd255, 8'd50);
        send_reading(8'd50, 8'd255, 8'd255, 8'd255);
        send_reading(8'd0, 8'd0, 8'd0, 8'd1);
        send_reading(8'd51, 8'd51, 8'd255, 8'd255);
        drain_results();
    endtask

    task automatic test_register_extremes();
        // Stop distance of zero: nothing is ever an obstacle, so the error reaches its peak.
        write_reg(oas_pkg::REG_STOP_DISTANCE, '0);
        write_reg(oas_pkg::REG_CRUISE_SPEED, '1);
        write_reg(oas_pkg::REG_TURN_SPEED, '1);
        write_reg(oas_pkg::REG_ERROR_LIMIT, '1);
        send_reading(8'd255, 8'd1, 8'd1, 8'd1);
        send_reading(8'd1, 8'd1, 8'd1, 8'd255);
        send_reading(8'd1, 8'd1, 8'd1, 8'd1);
        send_reading(8'd0, 8'd0, 8'd0, 8'd0);
        drain_results();
        write_reg(oas_pkg::REG_STOP_DISTANCE, '1);
        write_reg(oas_pkg::REG_CRUISE_SPEED, '0);
        write_reg(oas_pkg::REG_TURN_SPEED, '0);
        write_reg(oas_pkg::REG_ERROR_LIMIT, '0);
        send_reading(8'd255, 8'd255, 8'd255, 8'd255);
        send_reading(8'd255, 8'd1, 8'd255, 8'd255);
        send_reading(8'd255, 8'd255, 8'd255, 8'd254);
        send_reading(8'd255, 8'd255, 8'd255, 8'd255);
        drain_results();
        // Tight clamp with no cruise speed drives one wheel negative.
        write_reg(oas_pkg::REG_STOP_DISTANCE, '0);
        write_reg(oas_pkg::REG_TURN_SPEED, '1);
        write_reg(oas_pkg::REG_ERROR_LIMIT, 11'd100);
        send_reading(8'd255, 8'd1, 8'd1, 8'd1);
        send_reading(8'd1, 8'd1, 8'd1, 8'd255);
        drain_results();
        write_reg(oas_pkg::REG_STOP_DISTANCE, '1);
        send_reading(8'd1, 8'd2, 8'd3, 8'd4);
        send_reading(8'd0, 8'd0, 8'd0, 8'd0);
        send_reading(8'd200, 8'd0, 8'd0, 8'd0);
        drain_results();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (2) begin
            drain_results();
            load_random_config();
            repeat (n_items / 2) send_random_reading();
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_random_config();
        @(negedge i_clk);
        holdoff_req = 1'b1;
        repeat (30) send_random_reading();
        drain_results();
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_random_traffic(19, 61, 198);
        test_random_traffic(61, 19, 198);
        test_random_traffic(0, 0, 200);
        test_backpressure();
        if (fail_count == 0)
            $display("obstacle_avoid_steering_tb OK");
        else
            $display("obstacle_avoid_steering_tb NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/oas_pkg.sv
rtl/oas_cfg_regs.sv
rtl/oas_steer_calc.sv
rtl/obstacle_avoid_steering.sv
tb/obstacle_avoid_steering_tb.sv
